FILE: rtl/smq_pkg.sv
// ----------------------------------------------------------------------------
// smq_pkg
// Types and constants for the send match queue unit (smq_ram does not use them).
// ----------------------------------------------------------------------------
package smq_pkg;

  // request codes
  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  // query tag that matches any stored tag
  localparam logic [31:0] ANY_TAG = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               func;
    logic signed [31:0] msg_tag;
    logic        [15:0] peer_rank;
    logic signed [63:0] match_key;
    logic        [31:0] begin_ref;
    logic        [31:0] end_ref;
    logic        [47:0] file_pos;
    logic        [15:0] thread_id;
    logic        [15:0] vthread_id;
  } smq_req_t;

  typedef struct packed {
    logic        found;
    logic        full_res;
    logic [31:0] out_begin_ref;
    logic [31:0] out_end_ref;
    logic [47:0] out_file_pos;
    logic [15:0] out_thread;
    logic [15:0] out_vthread;
  } smq_res_t;

  typedef struct packed {
    logic [31:0] begin_ref;
    logic [31:0] end_ref;
    logic [47:0] file_pos;
    logic [15:0] thread_id;
    logic [15:0] vthread_id;
  } smq_payload_t;

  // one table row as held in memory
  typedef struct packed {
    logic         valid;
    logic [31:0]  tag;
    logic [15:0]  peer;
    logic [63:0]  key;
    smq_payload_t payload;
    logic [31:0]  age;
  } smq_entry_t;

endpackage

FILE: rtl/send_match_queue_unit.sv
// ----------------------------------------------------------------------------
// send_match_queue_unit
// Table of pending sends: insert into lowest free slot, extract oldest match.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start / busy           req (smq_req_t)
//  result    done (one-cycle pulse) res (smq_res_t)
//
//  Each request scans the table memory one row per cycle through its single
//  read port: an insert stops at the lowest free slot and writes it there,
//  while a full insert or an extract miss scans every row and an extract
//  hit scans every row and then frees the matched row in a write-back state.
//  After reset a clearing pass writes every row invalid with busy high.
//  The result pulse cannot be held off by the receiver.
module send_match_queue_unit
  import smq_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  smq_req_t req,
  output logic     done,
  output smq_res_t res
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0]   state;
  logic [IW-1:0] clr_idx;
  logic [IW-1:0] chk_idx;
  logic [IW-1:0] best_idx;
  logic [31:0]  best_dist;
  smq_payload_t best_pay;
  logic         hit;
  logic [31:0]  stamp;
  smq_req_t     req_q;

  logic         wr_en;
  logic [IW-1:0] wr_addr;
  smq_entry_t   wr_data;
  logic [IW-1:0] rd_addr;
  smq_entry_t   rd_data;

  logic         match;
  logic         better;
  logic [31:0]  age_gap;
  logic         last;

  smq_ram #(
    .WIDTH ($bits(smq_entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy = (state != ST_IDLE);

  // compare the row read back against the latched query
  always_comb begin
    match   = rd_data.valid
           && (rd_data.peer == req_q.peer_rank)
           && (rd_data.key == req_q.match_key)
           && ((req_q.msg_tag == ANY_TAG) || (rd_data.tag == req_q.msg_tag));
    age_gap = stamp - rd_data.age;
    better  = match && (!hit || (age_gap > best_dist));
    last    = (chk_idx == LAST);
  end

  // read address runs one row ahead of the row being checked
  always_comb begin
    rd_addr = (state == ST_SCAN) ? chk_idx + 1'b1 : '0;
  end

  // write port: clearing pass, insert, or freeing the matched row
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx;
    wr_data = '0;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = best_idx;
        if (req_q.func == FUNC_INSERT) begin
          wr_data.valid              = 1'b1;
          wr_data.tag                = req_q.msg_tag;
          wr_data.peer               = req_q.peer_rank;
          wr_data.key                = req_q.match_key;
          wr_data.payload.begin_ref  = req_q.begin_ref;
          wr_data.payload.end_ref    = req_q.end_ref;
          wr_data.payload.file_pos   = req_q.file_pos;
          wr_data.payload.thread_id  = req_q.thread_id;
          wr_data.payload.vthread_id = req_q.vthread_id;
          wr_data.age                = stamp;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      chk_idx <= '0;
      hit     <= 1'b0;
      stamp   <= '0;
      done    <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          done    <= 1'b0;
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          done <= 1'b0;
          if (start) begin
            req_q   <= req;
            chk_idx <= '0;
            hit     <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          chk_idx <= chk_idx + 1'b1;
          if (req_q.func == FUNC_INSERT) begin
            done <= rd_data.valid && last;
            if (!rd_data.valid) begin
              best_idx <= chk_idx;
              state    <= ST_WRITE;
            end else if (last) begin
              res   <= '{1'b0, 1'b1, 32'd0, 32'd0, 48'd0, 16'd0, 16'd0};
              state <= ST_IDLE;
            end
          end else begin
            done <= last && !(hit || better);
            if (better) begin
              hit       <= 1'b1;
              best_idx  <= chk_idx;
              best_dist <= age_gap;
              best_pay  <= rd_data.payload;
            end
            if (last) begin
              if (hit || better) begin
                state <= ST_WRITE;
              end else begin
                res   <= '0;
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_WRITE: begin
          done <= 1'b1;
          if (req_q.func == FUNC_INSERT) begin
            res   <= '0;
            stamp <= stamp + 1'b1;
          end else begin
            res <= '{1'b1, 1'b0, best_pay.begin_ref, best_pay.end_ref, best_pay.file_pos,
                     best_pay.thread_id, best_pay.vthread_id};
          end
          state <= ST_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only follows a scan or a write-back
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_SCAN || $past(state) == ST_WRITE))
    else $error("result without a preceding scan or write");

  // a hit never reports a dropped insert
  a_found_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.found && res.full_res))
    else $error("found and full both set");

  // no memory write while waiting for a request
  a_idle_nowr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !wr_en)
    else $error("table write while idle");

  // the stamp moves only on a stored insert
  a_stamp: assert property (@(posedge clk) disable iff (rst)
    ($past(state) != ST_WRITE) |-> $stable(stamp))
    else $error("insert stamp changed outside write-back");
`endif

endmodule

FILE: rtl/smq_ram.sv
// ----------------------------------------------------------------------------
// smq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
